@@ hdl/thermal_print_line_sequencer_unit_macros.svh @@
// Assertion macros used by the thermal print line sequencer top level.
`ifndef THERMAL_PRINT_LINE_SEQUENCER_UNIT_MACROS_SVH
`define THERMAL_PRINT_LINE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpls check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TPLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpls check failed");

`endif

@@ hdl/tpls_pkg.sv @@
// Types and constants of the thermal print line sequencer.
package tpls_pkg;

  localparam int unsigned OPCODE_W        = 2;
  localparam int unsigned FEED_W          = 16;
  localparam int unsigned FEED_CNT_W      = FEED_W + 1;
  localparam int unsigned TICK_W          = 5;
  localparam int unsigned PHASE_W         = 2;
  localparam int unsigned FRAME_TICKS_DEF = 16;

  // Frame ticks at which the motor steps, and the two ticks that follow each.
  localparam logic [TICK_W-1:0] TICK_STEP_A  = TICK_W'(1);
  localparam logic [TICK_W-1:0] TICK_S2_A    = TICK_W'(2);
  localparam logic [TICK_W-1:0] TICK_IDLE_A  = TICK_W'(3);
  localparam logic [TICK_W-1:0] TICK_STEP_B  = TICK_W'(9);
  localparam logic [TICK_W-1:0] TICK_S2_B    = TICK_W'(10);
  localparam logic [TICK_W-1:0] TICK_IDLE_B  = TICK_W'(11);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 2'd0,
    OP_LINE = 2'd1,
    OP_FEED = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [FEED_W-1:0]   feed_lines;
    logic                paper_out;
  } tpls_item_t;

  typedef struct packed {
    logic phase_a;
    logic phase_b;
    logic motor_enable;
    logic strobe_one;
    logic strobe_two;
    logic latch_pulse;
    logic busy_res;
  } tpls_res_t;

endpackage

@@ hdl/tpls_if.sv @@
// Handshake channels of the sequencer: command items in, pin level items out.
interface tpls_in_if import tpls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [FEED_W-1:0]   feed_lines;
  logic                paper_out;

  modport source (output valid, output opcode, output feed_lines, output paper_out,
                  input ready);
  modport sink   (input valid, input opcode, input feed_lines, input paper_out,
                  output ready);
endinterface

interface tpls_out_if import tpls_pkg::*; ();
  logic valid;
  logic ready;
  logic phase_a;
  logic phase_b;
  logic motor_enable;
  logic strobe_one;
  logic strobe_two;
  logic latch_pulse;
  logic busy_res;

  modport source (output valid, output phase_a, output phase_b, output motor_enable,
                  output strobe_one, output strobe_two, output latch_pulse,
                  output busy_res, input ready);
  modport sink   (input valid, input phase_a, input phase_b, input motor_enable,
                  input strobe_one, input strobe_two, input latch_pulse,
                  input busy_res, output ready);
endinterface

@@ hdl/thermal_print_line_sequencer_unit.sv @@
// Top level of the thermal print line sequencer: handshakes, item and result registers.
// Path: an accepted item is held in the item register, and its result is then registered
// in the result register and offered from there; an output stall can hold it in between.
// Throughput: one item per cycle unless the output stalls; tpls_ctrl steps once per item.
// Reset: rst_ni is asynchronous and active low; it empties both registers, parks the
// motor at phase index zero, clears the pin state in tpls_ctrl, sets the half-rate toggle.
`include "thermal_print_line_sequencer_unit_macros.svh"

module thermal_print_line_sequencer_unit import tpls_pkg::*; #(
  parameter int unsigned FRAME_TICKS = FRAME_TICKS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tpls_in_if.sink    in_i,
  tpls_out_if.source out_o
);

  // Item register: holds the accepted item until the state logic consumes it.
  tpls_item_t item_q;
  logic       item_vld_q;

  // Result register: holds the pin levels until the downstream side takes them.
  tpls_res_t  res_q;
  tpls_res_t  res_d;
  logic       res_vld_q;

  logic       res_free;
  logic       advance;
  logic       in_fire;

  // The result register can load when it is empty or is being emptied this cycle.
  assign res_free = ~res_vld_q | out_o.ready;
  // The held item is consumed, and the state moves on, whenever the result can load.
  assign advance  = item_vld_q & res_free;
  // A new item is taken while the item register is empty or is being drained, so
  // items flow at one per cycle while the result side keeps taking them. While a
  // result waits, one more item can still be taken into an empty item register, and
  // after that the input stalls for as long as the result keeps waiting.
  assign in_i.ready = ~item_vld_q | advance;
  assign in_fire    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.opcode     <= in_i.opcode;
      item_q.feed_lines <= in_i.feed_lines;
      item_q.paper_out  <= in_i.paper_out;
    end
  end

  // All sequencing state lives here and is updated once per consumed item.
  tpls_ctrl #(
    .FRAME_TICKS(FRAME_TICKS)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(item_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = res_vld_q;
  assign out_o.phase_a      = res_q.phase_a;
  assign out_o.phase_b      = res_q.phase_b;
  assign out_o.motor_enable = res_q.motor_enable;
  assign out_o.strobe_one   = res_q.strobe_one;
  assign out_o.strobe_two   = res_q.strobe_two;
  assign out_o.latch_pulse  = res_q.latch_pulse;
  assign out_o.busy_res     = res_q.busy_res;

  // A latch always opens a frame, so the same result must report the block busy.
  `TPLS_ASSERT_IMPL(a_latch_busy, clk_i, rst_ni, out_o.valid && out_o.latch_pulse, out_o.busy_res)
  // The two strobe groups are never driven together.
  `TPLS_ASSERT_IMPL(a_strobe_excl, clk_i, rst_ni, out_o.valid, !(out_o.strobe_one && out_o.strobe_two))
  // Input back-pressure only arises from a full pipe behind a stalled output.
  `TPLS_ASSERT_IMPL(a_ready_cause, clk_i, rst_ni, !in_i.ready, item_vld_q && out_o.valid && !out_o.ready)

endmodule

@@ hdl/tpls_ctrl.sv @@
// Sequencer state and the per-item next-state and pin level logic.
module tpls_ctrl import tpls_pkg::*; #(
  parameter int unsigned FRAME_TICKS = FRAME_TICKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  tpls_item_t item_i,
  output tpls_res_t  res_o
);

  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [TICK_W-1:0]     tick_q, tick_d, tick_inc;
  logic                  armed_q, armed_d;
  logic                  feed_q, feed_d;
  logic [FEED_CNT_W-1:0] cnt_q, cnt_d;
  logic [FEED_W-1:0]     target_q, target_d;
  logic                  toggle_q, toggle_d;
  logic                  pin_a_q, pin_a_d, pin_b_q, pin_b_d, pin_en_q, pin_en_d;
  logic                  pin_s1_q, pin_s1_d, pin_s2_q, pin_s2_d;
  logic                  latch;
  logic                  step_a, step_b;
  logic [PHASE_W-1:0]    phase_inc;

  // Full-step table: index 0 drives A only, 1 both, 2 B only, 3 neither.
  assign step_a    = ~phase_q[1];
  assign step_b    = phase_q[1] ^ phase_q[0];
  assign phase_inc = phase_q + 1'b1;
  assign tick_inc  = tick_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    armed_d  = armed_q;
    feed_d   = feed_q;
    cnt_d    = cnt_q;
    target_d = target_q;
    toggle_d = toggle_q;
    pin_a_d  = pin_a_q;
    pin_b_d  = pin_b_q;
    pin_en_d = pin_en_q;
    pin_s1_d = pin_s1_q;
    pin_s2_d = pin_s2_q;
    latch    = 1'b0;
    case (opcode_e'(item_i.opcode))
      OP_TICK: begin
        if (feed_q) begin
          // Feeding acts on every other tick only.
          toggle_d = ~toggle_q;
          if (toggle_q) begin
            if (cnt_q > {1'b0, target_q}) begin
              pin_en_d = 1'b0;
              cnt_d    = '0;
              feed_d   = 1'b0;
            end else begin
              pin_a_d  = step_a;
              pin_b_d  = step_b;
              phase_d  = phase_inc;
              pin_en_d = 1'b1;
              cnt_d    = cnt_q + 1'b1;
            end
          end
        end else if ((tick_q == '0) && (!armed_q || item_i.paper_out)) begin
          pin_s1_d = 1'b0;
          pin_s2_d = 1'b0;
          pin_en_d = 1'b0;
        end else begin
          if (tick_q == '0) begin
            armed_d = 1'b0;
            latch   = 1'b1;
          end
          case (tick_inc)
            TICK_STEP_A, TICK_STEP_B: begin
              pin_a_d  = step_a;
              pin_b_d  = step_b;
              phase_d  = phase_inc;
              pin_en_d = 1'b1;
              pin_s2_d = 1'b0;
              pin_s1_d = 1'b1;
            end
            TICK_S2_A, TICK_S2_B: begin
              pin_s2_d = 1'b1;
              pin_s1_d = 1'b0;
            end
            TICK_IDLE_A, TICK_IDLE_B: begin
              pin_s2_d = 1'b0;
              pin_s1_d = 1'b0;
              pin_en_d = 1'b0;
            end
            default: begin
            end
          endcase
          tick_d = (tick_inc >= TICK_W'(FRAME_TICKS)) ? '0 : tick_inc;
        end
      end
      OP_LINE: begin
        armed_d = 1'b1;
      end
      OP_FEED: begin
        target_d = item_i.feed_lines;
        feed_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      tick_q   <= '0;
      armed_q  <= 1'b0;
      feed_q   <= 1'b0;
      cnt_q    <= '0;
      target_q <= '0;
      toggle_q <= 1'b1;
      pin_a_q  <= 1'b0;
      pin_b_q  <= 1'b0;
      pin_en_q <= 1'b0;
      pin_s1_q <= 1'b0;
      pin_s2_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      armed_q  <= armed_d;
      feed_q   <= feed_d;
      cnt_q    <= cnt_d;
      target_q <= target_d;
      toggle_q <= toggle_d;
      pin_a_q  <= pin_a_d;
      pin_b_q  <= pin_b_d;
      pin_en_q <= pin_en_d;
      pin_s1_q <= pin_s1_d;
      pin_s2_q <= pin_s2_d;
    end
  end

  assign res_o.phase_a      = pin_a_d;
  assign res_o.phase_b      = pin_b_d;
  assign res_o.motor_enable = pin_en_d;
  assign res_o.strobe_one   = pin_s1_d;
  assign res_o.strobe_two   = pin_s2_d;
  assign res_o.latch_pulse  = latch;
  assign res_o.busy_res     = feed_d | (tick_d != '0);

endmodule

@@ test/tpls_level_checker.sv @@
// Checker that predicts the sequencer's pin levels per command item and compares them.
`timescale 1ns / 100ps

module tpls_level_checker import tpls_pkg::*; #(
  parameter int unsigned FRAME_TICKS = FRAME_TICKS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tpls_in_if   in_ch_i,
  tpls_out_if  out_ch_i,
  output int   pending_o,
  output int   fail_count_o
);

  // Predicted sequencer state.
  logic [PHASE_W-1:0]    step_phase;
  logic [TICK_W-1:0]     frame_pos;
  logic                  line_held;
  logic                  feeding;
  logic [FEED_CNT_W-1:0] feed_steps;
  logic [FEED_W-1:0]     feed_goal;
  logic                  half_step;
  logic                  pin_a, pin_b, pin_en, pin_s1, pin_s2;

  tpls_res_t levels_due_q[$];
  int        mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic advance_motor();
    pin_a      = (step_phase == PHASE_W'(0)) || (step_phase == PHASE_W'(1));
    pin_b      = (step_phase == PHASE_W'(1)) || (step_phase == PHASE_W'(2));
    step_phase = step_phase + 1'b1;
  endtask

  task automatic predict_levels(input tpls_item_t cmd, output tpls_res_t lv);
    logic latched;
    latched = 1'b0;
    case (cmd.opcode)
      OP_TICK: begin
        if (feeding) begin
          // The feed steps on every second tick and ends once the count passes the goal.
          half_step = ~half_step;
          if (!half_step) begin
            if (feed_steps > {1'b0, feed_goal}) begin
              pin_en     = 1'b0;
              feed_steps = '0;
              feeding    = 1'b0;
            end else begin
              advance_motor();
              pin_en     = 1'b1;
              feed_steps = feed_steps + 1'b1;
            end
          end
        end else if (frame_pos == '0 && (!line_held || cmd.paper_out)) begin
          pin_s1 = 1'b0;
          pin_s2 = 1'b0;
          pin_en = 1'b0;
        end else begin
          if (frame_pos == '0) begin
            line_held = 1'b0;
            latched   = 1'b1;
          end
          frame_pos = frame_pos + 1'b1;
          case (frame_pos)
            TICK_STEP_A, TICK_STEP_B: begin
              advance_motor();
              pin_en = 1'b1;
              pin_s2 = 1'b0;
              pin_s1 = 1'b1;
            end
            TICK_S2_A, TICK_S2_B: begin
              pin_s2 = 1'b1;
              pin_s1 = 1'b0;
            end
            TICK_IDLE_A, TICK_IDLE_B: begin
              pin_s2 = 1'b0;
              pin_s1 = 1'b0;
              pin_en = 1'b0;
            end
            default: ;
          endcase
          if (frame_pos >= TICK_W'(FRAME_TICKS)) frame_pos = '0;
        end
      end
      OP_LINE: line_held = 1'b1;
      OP_FEED: begin
        feed_goal = cmd.feed_lines;
        feeding   = 1'b1;
      end
      default: ;
    endcase
    lv = '{phase_a: pin_a, phase_b: pin_b, motor_enable: pin_en, strobe_one: pin_s1,
           strobe_two: pin_s2, latch_pulse: latched, busy_res: feeding || (frame_pos != '0)};
  endtask

  task automatic check_field(input string fname, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    tpls_res_t  got;
    tpls_res_t  want;
    tpls_item_t cmd;
    if (!rst_ni) begin
      step_phase = '0;
      frame_pos  = '0;
      line_held  = 1'b0;
      feeding    = 1'b0;
      feed_steps = '0;
      feed_goal  = '0;
      half_step  = 1'b1;
      {pin_a, pin_b, pin_en, pin_s1, pin_s2} = '0;
      levels_due_q.delete();
      pending_o <= 0;
    end else begin
      if (out_ch_i.valid && out_ch_i.ready) begin
        got = '{phase_a: out_ch_i.phase_a, phase_b: out_ch_i.phase_b,
                motor_enable: out_ch_i.motor_enable, strobe_one: out_ch_i.strobe_one,
                strobe_two: out_ch_i.strobe_two, latch_pulse: out_ch_i.latch_pulse,
                busy_res: out_ch_i.busy_res};
        if (levels_due_q.size() == 0) begin
          $error("pin level item arrived with none expected");
          mismatches++;
        end else begin
          want = levels_due_q.pop_front();
          check_field("phase_a", want.phase_a, got.phase_a);
          check_field("phase_b", want.phase_b, got.phase_b);
          check_field("motor_enable", want.motor_enable, got.motor_enable);
          check_field("strobe_one", want.strobe_one, got.strobe_one);
          check_field("strobe_two", want.strobe_two, got.strobe_two);
          check_field("latch_pulse", want.latch_pulse, got.latch_pulse);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
      if (in_ch_i.valid && in_ch_i.ready) begin
        cmd = '{opcode: in_ch_i.opcode, feed_lines: in_ch_i.feed_lines,
                paper_out: in_ch_i.paper_out};
        predict_levels(cmd, want);
        levels_due_q.push_back(want);
      end
      pending_o <= levels_due_q.size();
    end
  end

endmodule

@@ test/tb_thermal_print_line_sequencer_unit.sv @@
// Testbench top of the thermal print line sequencer: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb_thermal_print_line_sequencer_unit;
  import tpls_pkg::*;

  // Frame length used by both the block and the checker.
  localparam int unsigned FRAME_LEN = FRAME_TICKS_DEF;

  // The spare opcode, which the block must ignore.
  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

  // Cycles without any accepted item before the run is declared hung. Even with the
  // heaviest idling, a correct run never goes this long without accepting something,
  // so this is many times the worst gap.
  localparam int STALL_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   pending;
  int   fail_count;

  tpls_in_if  in_ch ();
  tpls_out_if out_ch ();

  thermal_print_line_sequencer_unit #(.FRAME_TICKS(FRAME_LEN)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tpls_level_checker #(.FRAME_TICKS(FRAME_LEN)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver withdraws ready at random, at the rate the current phase sets. It is
  // redrawn on every edge, so stalls fall on every phase of the block's work.
  initial out_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one item after a random number of idle cycles and holds it until accepted.
  // On return the current time step is the accepting edge, so the next call may change
  // valid straight away without a second assignment in the same step.
  task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [FEED_W-1:0] lines,
                           input logic paper);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.feed_lines <= lines;
    in_ch.paper_out  <= paper;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Holds the sender back until every expected pin level item has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random traffic. Most of it is well-formed: a line followed by enough ticks to run a
  // frame through, or a feed followed by the ticks it needs. The rest is loose items of
  // any opcode, the spare one included, with random payload bits.
  task automatic run_phase(input int src_pct, input int snk_pct, input int n_items);
    int                  sent;
    int                  kind;
    int                  len;
    bit                  paused;
    logic [OPCODE_W-1:0] op;
    logic [FEED_W-1:0]   lines;
    send_idle_pct = src_pct;
    recv_idle_pct = snk_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        push_item(OP_LINE, FEED_W'($urandom), 1'($urandom));
        sent++;
        len = $urandom_range(FRAME_LEN + 4, 4);
        repeat (len) begin
          // Paper runs out now and then, which holds the line armed.
          push_item(OP_TICK, FEED_W'($urandom), $urandom_range(19) == 0);
          sent++;
        end
      end else if (kind < 70) begin
        // Mostly short feeds; a long one now and then is cut short by the next feed,
        // since the step count carries over.
        lines = ($urandom_range(19) == 0) ? FEED_W'($urandom) : FEED_W'($urandom_range(6));
        push_item(OP_FEED, lines, 1'($urandom));
        sent++;
        len = (lines < 8) ? 2 * int'(lines) + 4 : int'($urandom_range(40, 10));
        repeat (len) begin
          push_item(OP_TICK, FEED_W'($urandom), 1'($urandom));
          sent++;
        end
      end else begin
        op = OPCODE_W'($urandom);
        push_item(op, FEED_W'($urandom), 1'($urandom));
        sent++;
      end
      // Halfway through each phase the sender waits for the block to empty.
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  // Watchdog: ends the run if nothing is accepted on either channel for too long.
  initial begin : watchdog
    int stall;
    stall = 0;
    wait (rst_ni === 1'b1);
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall = 0;
      else stall++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_TICK;
    in_ch.feed_lines = '0;
    in_ch.paper_out  = 1'b0;
    send_idle_pct    = 6;
    recv_idle_pct    = 78;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A tick with nothing armed leaves the block idle, and the spare
    // opcode changes nothing.
    push_item(OP_TICK, '0, 1'b0);
    push_item(OP_SPARE, '1, 1'b1);
    // A line is armed, but with paper out the tick stays idle.
    push_item(OP_LINE, '1, 1'b1);
    push_item(OP_TICK, '1, 1'b1);
    // Loading again while armed keeps one line armed; this tick latches it.
    push_item(OP_LINE, '0, 1'b0);
    push_item(OP_TICK, '0, 1'b0);
    // A line loaded during the frame waits for the next frame start.
    push_item(OP_LINE, '0, 1'b0);
    push_item(OP_TICK, '0, 1'b0);
    push_item(OP_TICK, '0, 1'b0);
    // A feed of zero lines in mid-frame takes priority: one step, then it ends.
    push_item(OP_FEED, '0, 1'b1);
    repeat (3) push_item(OP_TICK, '0, 1'b0);
    // The largest feed, replaced by a zero one while running: the step count is kept,
    // so the feed ends at its next stepping tick.
    push_item(OP_FEED, '1, 1'b0);
    repeat (2) push_item(OP_TICK, '1, 1'b0);
    push_item(OP_FEED, '0, 1'b1);
    repeat (2) push_item(OP_TICK, '0, 1'b0);
    // The paused frame resumes.
    repeat (6) push_item(OP_TICK, '0, 1'b0);
    drain();

    // Random part: first a slow receiver, then a slow sender, then no idling at all.
    run_phase(6, 78, 400);
    run_phase(78, 6, 400);
    run_phase(0, 0, 400);

    // Wait for the last pin levels, then keep clocking the block in case it
    // produces anything unexpected.
    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tpls_pkg.sv
hdl/tpls_if.sv
hdl/tpls_ctrl.sv
hdl/thermal_print_line_sequencer_unit.sv
test/tpls_level_checker.sv
test/tb_thermal_print_line_sequencer_unit.sv
